// ===== rtl/blkavg_pkg.sv =====
package blkavg_pkg;

  // Storage limits
  localparam int MaxBlockCols = 256;
  localparam int MaxBlockSize = 64;

  // Configuration register widths
  localparam int BlockSizeW = 7;
  localparam int BlockCntW  = 9;

  // Configuration register indexes
  localparam logic [1:0] REG_BLOCK_SIZE        = 2'd0;
  localparam logic [1:0] REG_BLOCKS_PER_ROW    = 2'd1;
  localparam logic [1:0] REG_BLOCKS_PER_COLUMN = 2'd2;

  // Reset values of the configuration registers
  localparam logic [BlockSizeW-1:0] BlockSizeRst       = 7'd8;
  localparam logic [BlockCntW-1:0]  BlocksPerRowRst    = 9'd80;
  localparam logic [BlockCntW-1:0]  BlocksPerColumnRst = 9'd60;

endpackage

// ===== rtl/block_average_downscale.sv =====
// Block-average downscaler (box filter).
//
// Slave stream s_axis_*: one pixel per transaction, blue/green/red in tdata,
// tuser high on the first pixel of a frame (restarts all position counters).
// Master stream m_axis_*: one transaction per finished square block with the
// truncated channel means, block column and block row; tlast marks the final
// block of the frame.
// Config channel cfg_*: index 0 block size, 1 blocks per row, 2 blocks per
// column. Any write to one of those restarts the position counters; an index
// beyond them is accepted and ignored. cfg_ready_o is always high.
// A pixel that does not close a block passes through accept (with the sum
// memory read issued), then add and write back. A pixel that closes a block
// goes on through a shared restoring divider (one quotient bit per cycle for
// all three channels) and the output register load. A new pixel is accepted
// only once the previous one is through.
// On a receiver stall the result sits in the output register; pixels keep
// flowing until the next block result, which waits for the register to free.
// Reset: registers take their reset values, counters go to zero, the output
// register empties. The sum memory needs no clearing: each block's first
// pixel overwrites its entry.
module block_average_downscale #(
  parameter int MAX_BLOCK_COLS = blkavg_pkg::MaxBlockCols,
  parameter int MAX_BLOCK_SIZE = blkavg_pkg::MaxBlockSize
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic        s_axis_tuser,   // start_of_frame
  // block result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // avg_blue[7:0], avg_green[15:8], avg_red[23:16], block_column[31:24],
  // block_row[39:32]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_of_frame
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  // counter, size and sum widths
  localparam int XW    = (MAX_BLOCK_SIZE > 1) ? $clog2(MAX_BLOCK_SIZE) : 1;
  localparam int SW    = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int CMPSW = (SW > blkavg_pkg::BlockSizeW) ? SW : blkavg_pkg::BlockSizeW;
  localparam int CW    = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
  localparam int BPRW  = $clog2(MAX_BLOCK_COLS + 1);
  localparam int CMPRW = (BPRW > blkavg_pkg::BlockCntW) ? BPRW : blkavg_pkg::BlockCntW;
  localparam int AREAW = $clog2(MAX_BLOCK_SIZE * MAX_BLOCK_SIZE + 1);
  localparam int SUMW  = $clog2(255 * MAX_BLOCK_SIZE * MAX_BLOCK_SIZE + 1);
  localparam int DW    = AREAW + 7;
  localparam int RW    = (SUMW > DW) ? SUMW : DW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // configuration
  logic [blkavg_pkg::BlockSizeW-1:0] block_size_q;
  logic [blkavg_pkg::BlockCntW-1:0]  bpr_cfg_q, bpc_cfg_q;
  logic                              cfg_write, cfg_restart;

  // position counters
  logic [XW-1:0] x_q, x_d, line_q, line_d;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    row_q, row_d;

  logic [1:0] state_q;

  // clamped geometry
  logic [CMPSW-1:0] s_ext, s_cl;
  logic [SW-1:0]    s;
  logic [CMPRW-1:0] bpr_ext, bpr_cl;
  logic [BPRW-1:0]  bpr;
  logic [8:0]       bpc;
  logic [AREAW-1:0] area_q;

  // effective position of the incoming pixel
  logic          in_accept, sof;
  logic [XW-1:0] x_eff, line_eff;
  logic [CW-1:0] col_eff;
  logic [7:0]    row_eff;
  logic [SW-1:0] x_plus, line_plus;
  logic [BPRW-1:0] col_plus;
  logic [8:0]    row_plus;
  logic          x_end, line_end, col_end, row_end;

  // item held through read, add and divide
  logic [7:0]    pix_b_q, pix_g_q, pix_r_q;
  logic [CW-1:0] item_col_q;
  logic [7:0]    item_row_q;
  logic          item_first_q, item_corner_q, item_last_q;

  // sum memory: {red, green, blue}
  logic [3*SUMW-1:0] sum_mem [MAX_BLOCK_COLS];
  logic [3*SUMW-1:0] rd_q, wr_data;
  logic [SUMW-1:0]   sum_b, sum_g, sum_r;

  // divider
  logic [RW-1:0] rem_b_q, rem_g_q, rem_r_q, dv_q;
  logic [7:0]    quo_b_q, quo_g_q, quo_r_q;
  logic [2:0]    step_q;
  logic          ge_b, ge_g, ge_r;

  // output register
  logic        out_valid_q;
  logic [39:0] out_data_q;
  logic        out_last_q;
  logic        out_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;
  assign cfg_restart = cfg_write &&
                       (cfg_index_i == blkavg_pkg::REG_BLOCK_SIZE ||
                        cfg_index_i == blkavg_pkg::REG_BLOCKS_PER_ROW ||
                        cfg_index_i == blkavg_pkg::REG_BLOCKS_PER_COLUMN);

  // clamp to legal ranges: 0 reads as 1, too large reads as the limit
  assign s_ext = CMPSW'(block_size_q);
  assign s_cl  = (s_ext == '0) ? CMPSW'(1) :
                 (s_ext > CMPSW'(MAX_BLOCK_SIZE)) ? CMPSW'(MAX_BLOCK_SIZE) : s_ext;
  assign s     = s_cl[SW-1:0];

  assign bpr_ext = CMPRW'(bpr_cfg_q);
  assign bpr_cl  = (bpr_ext == '0) ? CMPRW'(1) :
                   (bpr_ext > CMPRW'(MAX_BLOCK_COLS)) ? CMPRW'(MAX_BLOCK_COLS) : bpr_ext;
  assign bpr     = bpr_cl[BPRW-1:0];

  assign bpc = (bpc_cfg_q == '0) ? 9'd1 : (bpc_cfg_q > 9'd256) ? 9'd256 : bpc_cfg_q;

  // block area, registered from the clamped block size
  always_ff @(posedge clk_i) begin
    area_q <= AREAW'(s) * AREAW'(s);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign sof           = s_axis_tuser;

  assign x_eff    = sof ? '0 : x_q;
  assign line_eff = sof ? '0 : line_q;
  assign row_eff  = sof ? '0 : row_q;
  assign col_eff  = (sof || (BPRW'(col_q) >= bpr)) ? '0 : col_q;

  assign x_plus    = SW'(x_eff) + SW'(1);
  assign line_plus = SW'(line_eff) + SW'(1);
  assign col_plus  = BPRW'(col_eff) + BPRW'(1);
  assign row_plus  = 9'(row_eff) + 9'd1;
  assign x_end     = (x_plus >= s);
  assign line_end  = (line_plus >= s);
  assign col_end   = (col_plus >= bpr);
  assign row_end   = (row_plus >= bpc);

  // raster advance for the accepted pixel
  always_comb begin
    x_d    = x_end ? '0 : x_plus[XW-1:0];
    col_d  = col_eff;
    line_d = line_eff;
    row_d  = row_eff;
    if (x_end) begin
      col_d = col_end ? '0 : col_plus[CW-1:0];
      if (col_end) begin
        line_d = line_end ? '0 : line_plus[XW-1:0];
        if (line_end) begin
          row_d = row_end ? '0 : row_plus[7:0];
        end
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_b_q       <= s_axis_tdata[7:0];
      pix_g_q       <= s_axis_tdata[15:8];
      pix_r_q       <= s_axis_tdata[23:16];
      item_col_q    <= col_eff;
      item_row_q    <= row_eff;
      item_first_q  <= (x_eff == '0) && (line_eff == '0);
      item_corner_q <= x_end && line_end;
      item_last_q   <= row_end && col_end;
    end
  end

  // read-modify-write of the per-column sums; first pixel of a block overwrites
  assign sum_b = item_first_q ? SUMW'(pix_b_q) : rd_q[SUMW-1:0] + SUMW'(pix_b_q);
  assign sum_g = item_first_q ? SUMW'(pix_g_q) : rd_q[2*SUMW-1:SUMW] + SUMW'(pix_g_q);
  assign sum_r = item_first_q ? SUMW'(pix_r_q) : rd_q[3*SUMW-1:2*SUMW] + SUMW'(pix_r_q);
  assign wr_data = {sum_r, sum_g, sum_b};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC) begin
      sum_mem[item_col_q] <= wr_data;
    end
    if (in_accept) begin
      rd_q <= sum_mem[col_eff];
    end
  end

  // restoring divide by the block area, one quotient bit per cycle
  assign ge_b = (rem_b_q >= dv_q);
  assign ge_g = (rem_g_q >= dv_q);
  assign ge_r = (rem_r_q >= dv_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC) begin
      rem_b_q <= RW'(sum_b);
      rem_g_q <= RW'(sum_g);
      rem_r_q <= RW'(sum_r);
      dv_q    <= RW'(area_q) << 7;
    end else if (state_q == ST_DIV) begin
      rem_b_q <= ge_b ? rem_b_q - dv_q : rem_b_q;
      rem_g_q <= ge_g ? rem_g_q - dv_q : rem_g_q;
      rem_r_q <= ge_r ? rem_r_q - dv_q : rem_r_q;
      quo_b_q <= {quo_b_q[6:0], ge_b};
      quo_g_q <= {quo_g_q[6:0], ge_g};
      quo_r_q <= {quo_r_q[6:0], ge_r};
      dv_q    <= dv_q >> 1;
    end
  end

  // result waits in ST_OUT while the output register is still full
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {item_row_q, 8'(item_col_q), quo_r_q, quo_g_q, quo_b_q};
      out_last_q <= item_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= blkavg_pkg::BlockSizeRst;
      bpr_cfg_q    <= blkavg_pkg::BlocksPerRowRst;
      bpc_cfg_q    <= blkavg_pkg::BlocksPerColumnRst;
      x_q          <= '0;
      line_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      state_q      <= ST_IDLE;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index_i)
          blkavg_pkg::REG_BLOCK_SIZE:
            block_size_q <= cfg_data_i[blkavg_pkg::BlockSizeW-1:0];
          blkavg_pkg::REG_BLOCKS_PER_ROW:    bpr_cfg_q <= cfg_data_i;
          blkavg_pkg::REG_BLOCKS_PER_COLUMN: bpc_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (cfg_restart) begin
        x_q    <= '0;
        line_q <= '0;
        col_q  <= '0;
        row_q  <= '0;
      end else if (in_accept) begin
        x_q    <= x_d;
        line_q <= line_d;
        col_q  <= col_d;
        row_q  <= row_d;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          step_q  <= 3'd7;
          state_q <= item_corner_q ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (step_q == 3'd0) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q - 3'd1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Unused register slot: writes there must be accepted and change nothing
  localparam logic [1:0] RegSpare = 2'd3;

  // Cycles to let a pixel that closes no block finish before a register write
  localparam int SettleCycles = 16;
  // Cycles without any transaction before the run is declared hung
  localparam int WatchdogLimit = 3000;
  localparam int RandomPixels = 250;
  localparam int RandomBlocks = 48;

  // Packed so that blue lands in the low byte of tdata
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // {tlast, tdata} of one block transaction
  typedef struct packed {
    logic       last;
    logic [7:0] block_row;
    logic [7:0] block_column;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
  } block_t;

  // One row of the directed sequence: a register write or a pixel, with the
  // block result typed in where it is obvious
  typedef struct packed {
    bit         is_reg;
    logic [1:0] index;
    logic [8:0] value;
    pixel_t     px;
    logic       sof;
    bit         typed;
    block_t     blk;
  } step_t;

  localparam block_t NoBlk = '0;

  // Block fields: '{last, row, column, red, green, blue}
  localparam step_t DirectedPlan [18] = '{
    // reset geometry (8x8 blocks, 80 x 60): nothing completes
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h8000FF, 1'b1, 1'b0, NoBlk},
    // write to the spare slot: no effect, no counter restart
    '{1'b1, RegSpare, 9'h1FF, 24'h0, 1'b0, 1'b0, NoBlk},
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h01FF00, 1'b0, 1'b0, NoBlk},
    // 1x1 blocks, 2 across, zero rows clamps to one: frame is two pixels
    '{1'b1, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h0, 1'b0, 1'b0, NoBlk},
    '{1'b1, blkavg_pkg::REG_BLOCKS_PER_ROW, 9'd2, 24'h0, 1'b0, 1'b0, NoBlk},
    '{1'b1, blkavg_pkg::REG_BLOCKS_PER_COLUMN, 9'd0, 24'h0, 1'b0, 1'b0, NoBlk},
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h000000, 1'b1, 1'b1,
      '{1'b0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00}},
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'hFFFFFF, 1'b0, 1'b1,
      '{1'b1, 8'd0, 8'd1, 8'hFF, 8'hFF, 8'hFF}},
    // no frame start: counters wrap by themselves
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h030201, 1'b0, 1'b1,
      '{1'b0, 8'd0, 8'd0, 8'h03, 8'h02, 8'h01}},
    // frame start in mid frame
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'hF055AA, 1'b1, 1'b1,
      '{1'b0, 8'd0, 8'd0, 8'hF0, 8'h55, 8'hAA}},
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h0FAA55, 1'b0, 1'b1,
      '{1'b1, 8'd0, 8'd1, 8'h0F, 8'hAA, 8'h55}},
    // 2x2 single-block frame; the top data bits of the size write are dropped
    '{1'b1, blkavg_pkg::REG_BLOCK_SIZE, 9'h182, 24'h0, 1'b0, 1'b0, NoBlk},
    '{1'b1, blkavg_pkg::REG_BLOCKS_PER_ROW, 9'd1, 24'h0, 1'b0, 1'b0, NoBlk},
    '{1'b1, blkavg_pkg::REG_BLOCKS_PER_COLUMN, 9'd1, 24'h0, 1'b0, 1'b0, NoBlk},
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h0100FF, 1'b1, 1'b0, NoBlk},
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h0100FF, 1'b0, 1'b0, NoBlk},
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h0100FF, 1'b0, 1'b0, NoBlk},
    // mean truncates: blue 1017/4, red 3/4
    '{1'b0, blkavg_pkg::REG_BLOCK_SIZE, 9'd0, 24'h0000FC, 1'b0, 1'b1,
      '{1'b1, 8'd0, 8'd0, 8'h00, 8'h00, 8'hFE}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // blue[7:0], green[15:8], red[23:16]
  logic        s_axis_tuser = 1'b0; // start_of_frame
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // blue, green, red, block_column, block_row
  logic        m_axis_tlast;       // last_of_frame
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;

  block_average_downscale i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: register copies, per-column channel sums, position counters
  // ---------------------------------------------------------------------
  logic [blkavg_pkg::BlockSizeW-1:0] reg_size = blkavg_pkg::BlockSizeRst;
  logic [blkavg_pkg::BlockCntW-1:0]  reg_bpr  = blkavg_pkg::BlocksPerRowRst;
  logic [blkavg_pkg::BlockCntW-1:0]  reg_bpc  = blkavg_pkg::BlocksPerColumnRst;

  int unsigned sum_b [blkavg_pkg::MaxBlockCols];
  int unsigned sum_g [blkavg_pkg::MaxBlockCols];
  int unsigned sum_r [blkavg_pkg::MaxBlockCols];
  int unsigned x_pos, col_pos, line_pos, row_pos;

  block_t blocks_due [$];   // block averages still to come out, oldest first

  // Bookkeeping
  int mismatches;
  int pixels_sent;
  int blocks_seen;
  int writes_done;
  int quiet_cycles;

  // Traffic shaping, set per phase
  int  gap_pct;     // chance in 100 that the sender idles a cycle
  int  stall_pct;   // chance in 100 that the receiver stalls a cycle
  int  hold_req;    // long receiver hold-off requested by the stimulus
  int  hold_left;
  bit  tx_up;       // s_axis_tvalid is currently high

  function automatic int unsigned fit_range(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void home_counters();
    x_pos    = 0;
    col_pos  = 0;
    line_pos = 0;
    row_pos  = 0;
  endfunction

  // Accumulate one pixel; returns 1 with the block average when the pixel
  // closes a block.
  function automatic bit average_pixel(input pixel_t px, input logic sof,
                                       output block_t blk);
    int unsigned side, across, down, col, area;
    bit done;
    side   = fit_range(reg_size, blkavg_pkg::MaxBlockSize);
    across = fit_range(reg_bpr, blkavg_pkg::MaxBlockCols);
    down   = fit_range(reg_bpc, 256);
    blk    = '0;
    if (sof) home_counters();
    if (col_pos >= across) col_pos = 0;
    col = col_pos;
    // first pixel of a block replaces whatever the column held
    if (x_pos == 0 && line_pos == 0) begin
      sum_b[col] = px.blue;
      sum_g[col] = px.green;
      sum_r[col] = px.red;
    end else begin
      sum_b[col] += px.blue;
      sum_g[col] += px.green;
      sum_r[col] += px.red;
    end
    done = (x_pos + 1 >= side) && (line_pos + 1 >= side);
    if (done) begin
      area             = side * side;
      blk.avg_blue     = 8'(sum_b[col] / area);
      blk.avg_green    = 8'(sum_g[col] / area);
      blk.avg_red      = 8'(sum_r[col] / area);
      blk.block_column = 8'(col);
      blk.block_row    = 8'(row_pos);
      blk.last         = (row_pos + 1 >= down) && (col + 1 >= across);
    end
    // raster walk: pixel in block, block column, line in block, block row
    x_pos++;
    if (x_pos >= side) begin
      x_pos = 0;
      col_pos++;
      if (col_pos >= across) begin
        col_pos = 0;
        line_pos++;
        if (line_pos >= side) begin
          line_pos = 0;
          row_pos++;
          if (row_pos >= down) row_pos = 0;
        end
      end
    end
    return done;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one pixel and wait for its transaction. tvalid stays high on
  // return so back-to-back pixels never toggle it within one time step.
  task automatic send_pixel(input pixel_t px, input logic sof, input bit typed,
                            input block_t typed_blk);
    block_t blk;
    if ($urandom_range(99) < gap_pct) begin
      if (tx_up) begin
        s_axis_tvalid <= 1'b0;
        tx_up = 1'b0;
      end
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= sof;
    tx_up = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
    if (average_pixel(px, sof, blk) || typed) begin
      blocks_due.push_back(typed ? typed_blk : blk);
    end
  endtask

  // Register write; cfg_valid_i is left high for the caller to drop.
  task automatic write_reg(input logic [1:0] index, input logic [8:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    writes_done++;
    case (index)
      blkavg_pkg::REG_BLOCK_SIZE:        reg_size = value[blkavg_pkg::BlockSizeW-1:0];
      blkavg_pkg::REG_BLOCKS_PER_ROW:    reg_bpr  = value;
      blkavg_pkg::REG_BLOCKS_PER_COLUMN: reg_bpc  = value;
      default: ;
    endcase
    if (index != RegSpare) home_counters();
  endtask

  // Stop offering, wait for every pending block, then let the datapath drain.
  task automatic settle();
    if (tx_up) begin
      s_axis_tvalid <= 1'b0;
      tx_up = 1'b0;
    end
    do @(posedge clk_i); while (blocks_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One setting: program the geometry, then stream pixels in mostly
  // well-formed frames.
  task automatic run_phase(input logic [8:0] size_w, input logic [8:0] bpr_w,
                           input logic [8:0] bpc_w, input int n_px,
                           input int mode, input int hold);
    int unsigned frame_len, frame_pos;
    int tone;
    pixel_t px;
    logic sof;
    settle();
    write_reg(blkavg_pkg::REG_BLOCK_SIZE, size_w);
    write_reg(blkavg_pkg::REG_BLOCKS_PER_ROW, bpr_w);
    write_reg(blkavg_pkg::REG_BLOCKS_PER_COLUMN, bpc_w);
    if ($urandom_range(3) == 0) write_reg(RegSpare, 9'($urandom));
    cfg_valid_i <= 1'b0;
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 72; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 72; end
      default: begin gap_pct = 8; stall_pct = 8; end
    endcase
    // receiver goes quiet while the sender keeps pushing: input must stall
    if (hold > 0) hold_req = hold;
    frame_len = fit_range(reg_size, blkavg_pkg::MaxBlockSize)
                * fit_range(reg_size, blkavg_pkg::MaxBlockSize)
                * fit_range(reg_bpr, blkavg_pkg::MaxBlockCols) * fit_range(reg_bpc, 256);
    frame_pos = 0;
    tone = $urandom_range(2);
    for (int k = 0; k < n_px; k++) begin
      if (k == n_px / 2 && (hold > 0 || $urandom_range(2) == 0)) begin
        // sender pause until the block queue runs dry
        if (tx_up) begin
          s_axis_tvalid <= 1'b0;
          tx_up = 1'b0;
        end
        do @(posedge clk_i); while (blocks_due.size() != 0);
      end
      case (tone)
        0: px = pixel_t'($urandom);
        1: px = '{8'(255 - $urandom_range(3)), 8'(255 - $urandom_range(3)),
                  8'(255 - $urandom_range(3))};
        default: px = '{8'($urandom_range(3)), 8'($urandom_range(3)),
                        8'($urandom_range(3))};
      endcase
      // frame start mostly where it belongs, sometimes missing or early;
      // early ones scale with the frame so that large blocks still close
      sof = (frame_pos == 0 && $urandom_range(7) != 0) ||
            $urandom_range(4 * frame_len) == 0;
      if (sof) frame_pos = 0;
      frame_pos = (frame_pos + 1) % frame_len;
      send_pixel(px, sof, 1'b0, NoBlk);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls plus the occasional long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every block transaction with the oldest pending average
  always @(posedge clk_i) begin : check_blocks
    block_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata};
      blocks_seen++;
      if (blocks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected block: b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                   $realtime, got.avg_blue, got.avg_green, got.avg_red,
                   got.block_column, got.block_row, got.last);
      end else begin
        want = blocks_due.pop_front();
        if (got.avg_blue !== want.avg_blue || got.avg_green !== want.avg_green ||
            got.avg_red !== want.avg_red || got.block_column !== want.block_column ||
            got.block_row !== want.block_row || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: block mismatch", $realtime);
            $display("  exp b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                     want.avg_blue, want.avg_green, want.avg_red,
                     want.block_column, want.block_row, want.last);
            $display("  got b=%0d g=%0d r=%0d col=%0d row=%0d last=%0b",
                     got.avg_blue, got.avg_green, got.avg_red,
                     got.block_column, got.block_row, got.last);
          end
        end
      end
    end
  end

  // Watchdog: cycles in which no channel completes a transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int random_px, random_blocks, phase;
    logic [8:0] size_w, bpr_w, bpc_w;
    step_t row;
    mismatches  = 0;
    pixels_sent = 0;
    blocks_seen = 0;
    writes_done = 0;
    quiet_cycles = 0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 0;
    hold_left = 0;
    tx_up     = 1'b0;
    home_counters();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed sequence; register writes only once the block is idle
    for (int i = 0; i < $size(DirectedPlan); i++) begin
      row = DirectedPlan[i];
      if (row.is_reg) begin
        if (i == 0 || !DirectedPlan[i-1].is_reg) settle();
        write_reg(row.index, row.value);
        if (i == $size(DirectedPlan) - 1 || !DirectedPlan[i+1].is_reg)
          cfg_valid_i <= 1'b0;
      end else begin
        send_pixel(row.px, row.sof, row.typed, row.blk);
      end
    end

    // Geometry extremes: block side 127 clamps to 64 (partial block only),
    // a full 16x16 block, 256 block columns (511 clamps), 256 block rows with
    // a zero size, then a long receiver hold
    run_phase(9'h0FF, 9'd1, 9'd1, 100, 3, 0);
    run_phase(9'd16, 9'd1, 9'd1, 300, 2, 0);
    run_phase(9'd1, 9'h1FF, 9'd1, 280, 0, 0);
    run_phase(9'd0, 9'd1, 9'h100, 280, 1, 0);
    run_phase(9'd1, 9'd3, 9'd2, 150, 0, 300);

    // Random settings, mostly small so blocks finish often
    random_px = pixels_sent;
    random_blocks = blocks_seen + blocks_due.size();
    phase = 0;
    while (pixels_sent - random_px < RandomPixels ||
           blocks_seen + blocks_due.size() - random_blocks < RandomBlocks) begin
      size_w = {2'($urandom_range(3)),
                7'(($urandom_range(3) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 3))};
      bpr_w = ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 6));
      bpc_w = ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 4));
      run_phase(size_w, bpr_w, bpc_w, $urandom_range(40, 200), phase % 4, 0);
      phase++;
    end

    settle();
    $display("Covered %0d pixels, %0d block averages, %0d register writes over %0d settings,",
             pixels_sent, blocks_seen, writes_done, phase + 6);
    $display("incl. clamped block side, 16x16 blocks, 256 block columns and rows, %s",
             "early and missing frame starts.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching blocks", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
